// ----- src/fqp_pkg.sv -----
// ---------------------------------------------------------------------------
// fqp_pkg: shared types and constants for the FASTQ record parser
// Codes for input ops, field tags, status and parse phase, plus the
// result record that travels from the parser core to the output queue.
// ---------------------------------------------------------------------------
package fqp_pkg;

    // Default widths of the internal counters
    localparam int FQP_LEN_BITS        = 16;
    localparam int FQP_COUNT_BITS      = 32;
    localparam int FQP_BYTE_COUNT_BITS = 48;

    // Characters the parser looks for
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_END  = 2'd1,
        OP_FAIL = 2'd2,
        OP_RSVD = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        TAG_NONE    = 3'd0,
        TAG_ID      = 3'd1,
        TAG_COMMENT = 3'd2,
        TAG_SEQ     = 3'd3,
        TAG_QUAL    = 3'd4
    } t_tag;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_CLEAN_END    = 4'd1,
        ST_NO_AT        = 4'd2,
        ST_EMPTY_ID     = 4'd3,
        ST_EMPTY_SEQ    = 4'd4,
        ST_NO_PLUS      = 4'd5,
        ST_LEN_MISMATCH = 4'd6,
        ST_UNEXP_END    = 4'd7,
        ST_READ_FAIL    = 4'd8,
        ST_TOO_LONG     = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_ID      = 3'd1,
        PH_COMMENT = 3'd2,
        PH_SEQ     = 3'd3,
        PH_PLUS    = 3'd4,
        PH_QUAL    = 3'd5,
        PH_DISCARD = 3'd6
    } t_phase;

    typedef struct packed {
        logic        last_of_run;
        logic [47:0] bytes_consumed;
        logic [31:0] records_parsed;
        logic [31:0] line_number;
        t_status     status;
        logic        record_done;
        t_tag        field_tag;
        logic [7:0]  byte_out;
    } t_result;

    // One parse step: always res1, plus res0 ahead of it for a flushed CR
    typedef struct packed {
        logic    push;
        logic    two;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

// ----- src/fastq_record_parser.sv -----
// ---------------------------------------------------------------------------
// fastq_record_parser: streaming FASTQ record parser
// Tags each byte of a FASTQ stream as id, comment, sequence or quality and
// checks record structure, with sticky error status and position counters.
// ---------------------------------------------------------------------------
// The block takes one request per cycle while its result queue has room for
// two results: a raw byte, end of input or a read failure, selected by the
// input tuser. Every request gives one result, except a byte that follows a
// held CR other than LF: the held CR comes out first as its own result, then
// the result for the byte, the second marked by tlast. The result queue drains
// one result per cycle, so a request with two results holds the output for
// both. From input accept to the first result a request passes the input
// register, then is parsed into the result queue. Once the status is nonzero
// (clean end or any error) it stays so and the counters freeze until reset.
// ---------------------------------------------------------------------------
module fastq_record_parser #(
    parameter int LEN_BITS        = fqp_pkg::FQP_LEN_BITS,
    parameter int COUNT_BITS      = fqp_pkg::FQP_COUNT_BITS,
    parameter int BYTE_COUNT_BITS = fqp_pkg::FQP_BYTE_COUNT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]   i_s_axis_tuser,   // [1:0] op
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] byte_out, [8] record_done, [12:9] status, [44:13] line_number,
    // [76:45] records_parsed, [124:77] bytes_consumed, [127:125] zero
    output logic [127:0] o_m_axis_tdata,
    output logic [2:0]   o_m_axis_tuser,   // [2:0] field_tag
    output logic         o_m_axis_tlast    // last_of_run
);
    import fqp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_byte;

    logic    w_space;
    logic    w_fire;
    t_push   w_push;
    t_result w_head;

    // request moves into the parser only when the queue can take two results
    assign w_fire          = r_in_valid && w_space;
    assign o_s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
    end

    fqp_parse #(
        .LEN_BITS       (LEN_BITS),
        .COUNT_BITS     (COUNT_BITS),
        .BYTE_COUNT_BITS(BYTE_COUNT_BITS)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_fire),
        .i_op   (r_in_op),
        .i_byte (r_in_byte),
        .o_push (w_push)
    );

    fqp_result_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_space(w_space),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_head (w_head)
    );

    assign o_m_axis_tdata = {3'b000,
                             w_head.bytes_consumed,
                             w_head.records_parsed,
                             w_head.line_number,
                             w_head.status,
                             w_head.record_done,
                             w_head.byte_out};
    assign o_m_axis_tuser = w_head.field_tag;
    assign o_m_axis_tlast = w_head.last_of_run;

endmodule

// ----- src/fqp_parse.sv -----
// ---------------------------------------------------------------------------
// fqp_parse: FASTQ line and record state machine
// Holds the parse state and counters; turns one request into one or two
// result records combinationally, in the same cycle as the request.
// ---------------------------------------------------------------------------
module fqp_parse #(
    parameter int LEN_BITS        = fqp_pkg::FQP_LEN_BITS,
    parameter int COUNT_BITS      = fqp_pkg::FQP_COUNT_BITS,
    parameter int BYTE_COUNT_BITS = fqp_pkg::FQP_BYTE_COUNT_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_op,
    input  logic [7:0]    i_byte,
    output fqp_pkg::t_push o_push
);
    import fqp_pkg::*;

    typedef struct packed {
        t_phase                     phase;
        logic                       cr_held;
        logic                       line_has;
        logic                       id_ne;
        logic [LEN_BITS-1:0]        seq_len;
        logic [LEN_BITS-1:0]        qual_len;
        logic [COUNT_BITS-1:0]      lines;
        logic [COUNT_BITS-1:0]      recs;
        logic [BYTE_COUNT_BITS-1:0] bytes;
        logic [BYTE_COUNT_BITS-1:0] line_bytes;
        t_status                    pending;
        t_status                    sticky;
    } t_state;

    t_state r_st, n_st, w_mid;
    t_tag   w_tag0, w_tag1;
    logic   w_done, w_two;

    // One literal line byte
    function automatic t_state f_take(input t_state s, input logic [7:0] c,
                                      output t_tag tag);
        t_state t;
        logic   first;
        t     = s;
        tag   = TAG_NONE;
        first = !s.line_has;
        t.line_has = 1'b1;
        unique case (s.phase)
            PH_WAIT: begin
                if (c == CH_AT) begin
                    t.phase = PH_ID;
                    t.id_ne = 1'b0;
                end else begin
                    t.pending = ST_NO_AT;
                    t.phase   = PH_DISCARD;
                end
            end
            PH_ID: begin
                if (c == CH_SPACE) begin
                    if (!s.id_ne) begin
                        t.pending = ST_EMPTY_ID;
                        t.phase   = PH_DISCARD;
                    end else begin
                        t.phase = PH_COMMENT;
                        tag     = TAG_COMMENT;
                    end
                end else begin
                    t.id_ne = 1'b1;
                    tag     = TAG_ID;
                end
            end
            PH_COMMENT: tag = TAG_COMMENT;
            PH_SEQ: begin
                if (&s.seq_len) begin
                    t.sticky = ST_TOO_LONG;
                end else begin
                    t.seq_len = s.seq_len + LEN_BITS'(1);
                    tag       = TAG_SEQ;
                end
            end
            PH_PLUS: begin
                if (first && c != CH_PLUS) begin
                    t.pending = ST_NO_PLUS;
                    t.phase   = PH_DISCARD;
                end
            end
            PH_QUAL: begin
                if (&s.qual_len) begin
                    t.sticky = ST_TOO_LONG;
                end else begin
                    t.qual_len = s.qual_len + LEN_BITS'(1);
                    tag        = TAG_QUAL;
                end
            end
            default: ;
        endcase
        return t;
    endfunction

    // Close the open line: counters move, line-level checks fire
    function automatic t_state f_end_line(input t_state s, output logic done);
        t_state t;
        t    = s;
        done = 1'b0;
        t.lines      = s.lines + COUNT_BITS'(1);
        t.bytes      = s.bytes + s.line_bytes;
        t.line_bytes = '0;
        t.line_has   = 1'b0;
        t.cr_held    = 1'b0;
        unique case (s.phase)
            PH_ID: begin
                if (!s.id_ne) begin
                    t.sticky = ST_EMPTY_ID;
                end else begin
                    t.phase   = PH_SEQ;
                    t.seq_len = '0;
                end
            end
            PH_COMMENT: begin
                t.phase   = PH_SEQ;
                t.seq_len = '0;
            end
            PH_SEQ: begin
                if (s.seq_len == '0) t.sticky = ST_EMPTY_SEQ;
                else                 t.phase  = PH_PLUS;
            end
            PH_PLUS: begin
                if (!s.line_has) begin
                    t.sticky = ST_NO_PLUS;
                end else begin
                    t.phase    = PH_QUAL;
                    t.qual_len = '0;
                end
            end
            PH_QUAL: begin
                if (s.qual_len != s.seq_len) begin
                    t.sticky = ST_LEN_MISMATCH;
                end else begin
                    t.recs  = s.recs + COUNT_BITS'(1);
                    t.phase = PH_WAIT;
                    done    = 1'b1;
                end
            end
            PH_DISCARD: t.sticky = (s.pending != ST_OK) ? s.pending : ST_NO_AT;
            default: ;
        endcase
        return t;
    endfunction

    function automatic t_result f_result(input t_state s, input logic [7:0] b,
                                         input t_tag tag, input logic done,
                                         input logic last);
        t_result r;
        r.byte_out       = (tag != TAG_NONE) ? b : 8'd0;
        r.field_tag      = tag;
        r.record_done    = done;
        r.status         = s.sticky;
        r.line_number    = 32'(s.lines);
        r.records_parsed = 32'(s.recs);
        r.bytes_consumed = 48'(s.bytes);
        r.last_of_run    = last;
        return r;
    endfunction

    // Next state
    always_comb begin
        t_state s;
        t_tag   tg0, tg1;
        logic   dn, two;
        s     = r_st;
        tg0   = TAG_NONE;
        tg1   = TAG_NONE;
        dn    = 1'b0;
        two   = 1'b0;
        w_mid = r_st;
        if (i_valid && r_st.sticky == ST_OK) begin
            unique case (t_op'(i_op))
                OP_DATA: begin
                    // held CR not followed by LF goes out late as a line byte
                    if (s.cr_held && i_byte != CH_LF) begin
                        s.cr_held = 1'b0;
                        s   = f_take(s, CH_CR, tg0);
                        two = 1'b1;
                    end
                    w_mid = s;
                    if (s.sticky == ST_OK) begin
                        s.line_bytes = s.line_bytes + BYTE_COUNT_BITS'(1);
                        if (i_byte == CH_CR)      s.cr_held = 1'b1;
                        else if (i_byte == CH_LF) s = f_end_line(s, dn);
                        else                      s = f_take(s, i_byte, tg1);
                    end
                end
                OP_END: begin
                    if (s.line_has || s.cr_held) s = f_end_line(s, dn);
                    if (s.sticky == ST_OK)
                        s.sticky = (s.phase == PH_WAIT) ? ST_CLEAN_END : ST_UNEXP_END;
                end
                OP_FAIL: begin
                    s.line_bytes = '0;
                    s.line_has   = 1'b0;
                    s.cr_held    = 1'b0;
                    s.sticky     = ST_READ_FAIL;
                end
                OP_RSVD: ;
            endcase
        end
        n_st   = s;
        w_tag0 = tg0;
        w_tag1 = tg1;
        w_done = dn;
        w_two  = two;
    end

    // Outputs
    always_comb begin
        o_push.push = i_valid;
        o_push.two  = i_valid && w_two;
        o_push.res0 = f_result(w_mid, CH_CR, w_tag0, 1'b0, 1'b0);
        o_push.res1 = f_result(n_st, i_byte, w_tag1, w_done, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase      <= PH_WAIT;
            r_st.cr_held    <= 1'b0;
            r_st.line_has   <= 1'b0;
            r_st.id_ne      <= 1'b0;
            r_st.seq_len    <= '0;
            r_st.qual_len   <= '0;
            r_st.lines      <= '0;
            r_st.recs       <= '0;
            r_st.bytes      <= '0;
            r_st.line_bytes <= '0;
            r_st.pending    <= ST_OK;
            r_st.sticky     <= ST_OK;
        end else if (i_valid) begin
            r_st <= n_st;
        end
    end

endmodule

// ----- src/fqp_result_fifo.sv -----
// ---------------------------------------------------------------------------
// fqp_result_fifo: result queue
// Four-entry queue taking one or two results per cycle, draining one.
// ---------------------------------------------------------------------------
module fqp_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fqp_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output fqp_pkg::t_result o_head
);
    import fqp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_pop;
    logic [CNT_W-1:0]  w_push_n;

    // room for the worst case of two results
    assign o_space  = r_count <= CNT_W'(DEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_head   = r_mem[r_rd];
    assign w_pop    = o_valid && i_ready;
    assign w_push_n = !i_push.push ? CNT_W'(0) : (i_push.two ? CNT_W'(2) : CNT_W'(1));

    always_comb begin
        n_wr    = r_wr + PTR_W'(w_push_n);
        n_rd    = w_pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + w_push_n - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            if (i_push.two) begin
                r_mem[r_wr]               <= i_push.res0;
                r_mem[r_wr + PTR_W'(1)]   <= i_push.res1;
            end else begin
                r_mem[r_wr]               <= i_push.res1;
            end
        end
    end

endmodule

// ----- test/fastq_result_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fastq_result_checker: result checker for the FASTQ record parser
// Watches both stream channels, keeps its own parse state, predicts the
// results of every accepted request and compares them in order.
// ---------------------------------------------------------------------------
module fastq_result_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]       i_s_tuser,   // [1:0] op
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    // [7:0] byte_out, [8] record_done, [12:9] status, [44:13] line_number,
    // [76:45] records_parsed, [124:77] bytes_consumed, [127:125] zero
    input  logic [127:0]     i_m_tdata,
    input  logic [2:0]       i_m_tuser,   // [2:0] field_tag
    input  logic             i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output logic [31:0]      o_records,
    output fqp_pkg::t_status o_final_status
);
    import fqp_pkg::*;

    // predicted parser state
    t_phase      ph;
    bit          cr_pend;
    bit          line_lit;
    bit          id_seen;
    logic [15:0] seq_len;
    logic [15:0] qual_len;
    logic [31:0] n_lines;
    logic [31:0] n_records;
    logic [47:0] n_bytes;
    logic [47:0] open_bytes;
    t_status     pend_err;
    t_status     status;

    t_result     results_due[$];
    int          fails;
    int          checked;

    function automatic t_result make_result(input logic [7:0] b, input t_tag tg,
                                            input bit done);
        t_result r;
        r.byte_out       = (tg != TAG_NONE) ? b : 8'h00;
        r.field_tag      = tg;
        r.record_done    = done;
        r.status         = status;
        r.line_number    = n_lines;
        r.records_parsed = n_records;
        r.bytes_consumed = n_bytes;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    // Tag one literal line byte and advance the phase
    function automatic t_tag classify_char(input logic [7:0] c);
        bit first;
        first    = !line_lit;
        line_lit = 1'b1;
        case (ph)
            PH_WAIT: begin
                if (c == CH_AT) begin
                    ph      = PH_ID;
                    id_seen = 1'b0;
                end else begin
                    pend_err = ST_NO_AT;
                    ph       = PH_DISCARD;
                end
                return TAG_NONE;
            end
            PH_ID: begin
                if (c == CH_SPACE) begin
                    if (!id_seen) begin
                        pend_err = ST_EMPTY_ID;
                        ph       = PH_DISCARD;
                        return TAG_NONE;
                    end
                    ph = PH_COMMENT;
                    return TAG_COMMENT;
                end
                id_seen = 1'b1;
                return TAG_ID;
            end
            PH_COMMENT: return TAG_COMMENT;
            PH_SEQ: begin
                if (seq_len == 16'hFFFF) begin
                    status = ST_TOO_LONG;
                    return TAG_NONE;
                end
                seq_len = seq_len + 16'd1;
                return TAG_SEQ;
            end
            PH_PLUS: begin
                if (first && c != CH_PLUS) begin
                    pend_err = ST_NO_PLUS;
                    ph       = PH_DISCARD;
                end
                return TAG_NONE;
            end
            PH_QUAL: begin
                if (qual_len == 16'hFFFF) begin
                    status = ST_TOO_LONG;
                    return TAG_NONE;
                end
                qual_len = qual_len + 16'd1;
                return TAG_QUAL;
            end
            default: return TAG_NONE;
        endcase
    endfunction

    // Close the open line; returns one when a valid record just ended
    function automatic bit close_line();
        bit had;
        had        = line_lit;
        n_lines    = n_lines + 32'd1;
        n_bytes    = n_bytes + open_bytes;
        open_bytes = '0;
        line_lit   = 1'b0;
        cr_pend    = 1'b0;
        case (ph)
            PH_ID: begin
                if (!id_seen) begin
                    status = ST_EMPTY_ID;
                end else begin
                    ph      = PH_SEQ;
                    seq_len = '0;
                end
            end
            PH_COMMENT: begin
                ph      = PH_SEQ;
                seq_len = '0;
            end
            PH_SEQ: begin
                if (seq_len == 16'd0) status = ST_EMPTY_SEQ;
                else ph = PH_PLUS;
            end
            PH_PLUS: begin
                if (!had) begin
                    status = ST_NO_PLUS;
                end else begin
                    ph       = PH_QUAL;
                    qual_len = '0;
                end
            end
            PH_QUAL: begin
                if (qual_len != seq_len) begin
                    status = ST_LEN_MISMATCH;
                end else begin
                    n_records = n_records + 32'd1;
                    ph        = PH_WAIT;
                    return 1'b1;
                end
            end
            PH_DISCARD: status = (pend_err != ST_OK) ? pend_err : ST_NO_AT;
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Work out the one or two results of an accepted request
    task automatic parse_request(input t_op op, input logic [7:0] c);
        t_result flushed;
        t_result r;
        bit      two;
        bit      done;
        t_tag    tg;
        two  = 1'b0;
        done = 1'b0;
        tg   = TAG_NONE;
        if (status != ST_OK || op == OP_RSVD) begin
            r = make_result(8'h00, TAG_NONE, 1'b0);
        end else if (op == OP_DATA) begin
            // held CR not followed by LF becomes an ordinary line byte
            if (cr_pend && c != CH_LF) begin
                cr_pend = 1'b0;
                tg      = classify_char(CH_CR);
                flushed = make_result(CH_CR, tg, 1'b0);
                two     = 1'b1;
                tg      = TAG_NONE;
            end
            if (status == ST_OK) begin
                open_bytes = open_bytes + 48'd1;
                if (c == CH_CR) cr_pend = 1'b1;
                else if (c == CH_LF) done = close_line();
                else tg = classify_char(c);
            end
            r = make_result(c, tg, done);
        end else if (op == OP_END) begin
            if (line_lit || cr_pend) done = close_line();
            if (status == ST_OK) status = (ph == PH_WAIT) ? ST_CLEAN_END : ST_UNEXP_END;
            r = make_result(8'h00, TAG_NONE, done);
        end else begin
            open_bytes = '0;
            line_lit   = 1'b0;
            cr_pend    = 1'b0;
            status     = ST_READ_FAIL;
            r          = make_result(8'h00, TAG_NONE, 1'b0);
        end
        r.last_of_run = 1'b1;
        if (two) results_due.push_back(flushed);
        results_due.push_back(r);
    endtask

    task automatic show_result(input string label, input t_result r);
        $display("  %s byte=%02h tag=%0d done=%b status=%0d line=%0d records=%0d bytes=%0d last=%b",
                 label, r.byte_out, r.field_tag, r.record_done, r.status, r.line_number,
                 r.records_parsed, r.bytes_consumed, r.last_of_run);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            ph         = PH_WAIT;
            cr_pend    = 1'b0;
            line_lit   = 1'b0;
            id_seen    = 1'b0;
            seq_len    = '0;
            qual_len   = '0;
            n_lines    = '0;
            n_records  = '0;
            n_bytes    = '0;
            open_bytes = '0;
            pend_err   = ST_OK;
            status     = ST_OK;
            results_due.delete();
            fails      = 0;
            checked    = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) parse_request(t_op'(i_s_tuser), i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got.byte_out       = i_m_tdata[7:0];
                got.record_done    = i_m_tdata[8];
                got.status         = t_status'(i_m_tdata[12:9]);
                got.line_number    = i_m_tdata[44:13];
                got.records_parsed = i_m_tdata[76:45];
                got.bytes_consumed = i_m_tdata[124:77];
                got.field_tag      = t_tag'(i_m_tuser);
                got.last_of_run    = i_m_tlast;
                if (results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("[%0t] mismatch: result with no request waiting", $realtime);
                        show_result("actual  ", got);
                    end
                end else begin
                    want = results_due.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] mismatch on result %0d", $realtime, checked);
                            show_result("expected", want);
                            show_result("actual  ", got);
                        end
                    end
                end
            end
        end
        o_fail_count   = fails;
        o_pending      = results_due.size();
        o_checked      = checked;
        o_records      = n_records;
        o_final_status = status;
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the FASTQ record parser
// Feeds a short directed stream, then mostly well-formed random records with
// CR/LF variations and ignored ops, and ends the stream with one randomly
// chosen terminal case (clean end, an error, or a sequence overflow). The
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
    import fqp_pkg::*;

    // Status is sticky until reset and reset happens once, so each run can
    // reach only one terminal status; the seed picks which one.
    typedef enum int {
        END_CLEAN,
        END_OPEN_LINE,
        END_MID_RECORD,
        END_READ_FAIL,
        END_NO_AT,
        END_EMPTY_ID,
        END_EMPTY_SEQ,
        END_NO_PLUS,
        END_LEN_MISMATCH,
        END_TOO_LONG
    } t_ending;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int PAUSE_AT      = 800;
    localparam int DRAIN_CYCLES  = 20;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [7:0]   s_data  = 8'h00;
    logic [1:0]   s_user  = 2'd0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [127:0] m_data;
    logic [2:0]   m_user;
    logic         m_last;

    int           fail_count;
    int           pending;
    int           checked;
    logic [31:0]  records;
    t_status      final_status;

    int           cycle_count = 0;
    int           requests_sent = 0;
    bit           no_idle = 1'b0;     // burst stretch: neither side idles
    int           sink_stall = 0;
    t_ending      ending;

    always #10 i_clk = ~i_clk;

    fastq_record_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    fastq_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_valid),
        .i_s_tready     (s_ready),
        .i_s_tdata      (s_data),
        .i_s_tuser      (s_user),
        .i_m_tvalid     (m_valid),
        .i_m_tready     (m_ready),
        .i_m_tdata      (m_data),
        .i_m_tuser      (m_user),
        .i_m_tlast      (m_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_records      (records),
        .o_final_status (final_status)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        if (no_idle) begin
            m_ready    <= 1'b1;
            sink_stall  = 0;
        end else if (sink_stall > 0) begin
            m_ready    <= 1'b0;
            sink_stall--;
        end else begin
            m_ready    <= 1'b1;
            sink_stall  = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // One request: optional gap, then hold until accepted. Returns at the
    // accepting rising edge; valid stays high into the next request.
    task automatic send_request(input t_op op, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= op;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    // Data byte, now and then preceded by an unused-op request
    task automatic send_data(input logic [7:0] b);
        if ($urandom_range(0, 49) == 0) send_request(OP_RSVD, 8'($urandom_range(0, 255)));
        send_request(OP_DATA, b);
    endtask

    // Stop sending until every predicted result has come out
    task automatic drain();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // Any byte but LF (and but space when no_space is set), biased toward the characters the parser looks at
    function automatic logic [7:0] pick_text_byte(input bit no_space);
        logic [7:0] b;
        do begin
            case ($urandom_range(0, 9))
                0: b = CH_CR;
                1: b = CH_AT;
                2: b = CH_PLUS;
                3: b = CH_SPACE;
                default: b = 8'($urandom_range(0, 255));
            endcase
        end while (b == CH_LF || (no_space && b == CH_SPACE));
        return b;
    endfunction

    // clean_tail: last byte is never CR, so a following newline cannot swallow it and the length holds
    task automatic send_body(input int len, input bit no_space, input bit clean_tail);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            b = pick_text_byte(no_space);
            while (clean_tail && k == len - 1 && b == CH_CR) b = pick_text_byte(no_space);
            send_data(b);
        end
    endtask

    task automatic send_newline();
        if ($urandom_range(0, 9) < 3) send_data(CH_CR);
        send_data(CH_LF);
    endtask

    task automatic send_header();
        send_data(CH_AT);
        send_body($urandom_range(1, 6), 1'b1, 1'b1);
        if ($urandom_range(0, 1)) begin
            send_data(CH_SPACE);
            send_body($urandom_range(0, 8), 1'b0, 1'b0);
        end
        send_newline();
    endtask

    task automatic send_plus_line();
        send_data(CH_PLUS);
        send_body($urandom_range(0, 4), 1'b0, 1'b0);
        send_newline();
    endtask

    function automatic int pick_seq_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 12);
        return $urandom_range(30, 90);
    endfunction

    // Full record, possibly after skipped empty lines
    task automatic send_record();
        int len;
        len = pick_seq_len();
        if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 2)) send_newline();
        send_header();
        send_body(len, 1'b0, 1'b1);
        send_newline();
        send_plus_line();
        send_body(len, 1'b0, 1'b1);
        send_newline();
    endtask

    // Terminal part of the stream; everything after it is frozen
    task automatic send_ending(input t_ending kind);
        int         len;
        logic [7:0] b;
        len = pick_seq_len();
        case (kind)
            END_CLEAN: send_request(OP_END, 8'($urandom_range(0, 255)));
            END_OPEN_LINE: begin
                // last quality line without LF, maybe with a dropped CR
                send_header();
                send_body(len, 1'b0, 1'b1);
                send_newline();
                send_plus_line();
                send_body(len, 1'b0, 1'b1);
                if ($urandom_range(0, 1)) send_data(CH_CR);
                send_request(OP_END, 8'($urandom_range(0, 255)));
            end
            END_MID_RECORD: begin
                send_header();
                if ($urandom_range(0, 1)) send_body(len, 1'b0, 1'b0);
                send_request(OP_END, 8'($urandom_range(0, 255)));
            end
            END_READ_FAIL: begin
                send_data(CH_AT);
                send_body($urandom_range(0, 5), 1'b0, 1'b0);
                send_request(OP_FAIL, 8'($urandom_range(0, 255)));
            end
            END_NO_AT: begin
                do b = pick_text_byte(1'b0); while (b == CH_AT || b == CH_CR);
                send_data(b);
                send_body($urandom_range(0, 4), 1'b0, 1'b0);
                send_newline();
            end
            END_EMPTY_ID: begin
                send_data(CH_AT);
                if ($urandom_range(0, 1)) begin
                    send_data(CH_SPACE);
                    send_body($urandom_range(0, 4), 1'b0, 1'b0);
                end
                send_newline();
            end
            END_EMPTY_SEQ: begin
                send_header();
                send_newline();
            end
            END_NO_PLUS: begin
                send_header();
                send_body(len, 1'b0, 1'b1);
                send_newline();
                if ($urandom_range(0, 1)) begin
                    do b = pick_text_byte(1'b0); while (b == CH_PLUS || b == CH_CR);
                    send_data(b);
                end
                send_newline();
            end
            END_LEN_MISMATCH: begin
                send_header();
                send_body(len, 1'b0, 1'b1);
                send_newline();
                send_plus_line();
                send_body($urandom_range(0, 1) ? len + 1 : len - 1, 1'b0, 1'b1);
                send_newline();
            end
            END_TOO_LONG: begin
                // five bytes past the 16-bit length limit of 65535, sent flat out
                no_idle = 1'b1;
                send_data(CH_AT);
                send_data(8'h41);
                send_newline();
                for (int k = 0; k < 65540; k++) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
                    send_request(OP_DATA, b);
                end
                no_idle = 1'b0;
            end
            default: ;
        endcase
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: skipped empty lines, unused op, header with comment and
        // dropped CR, sequence with byte extremes, quality with a late CR.
        send_request(OP_DATA, CH_LF);
        send_request(OP_DATA, CH_CR);
        send_request(OP_DATA, CH_LF);
        send_request(OP_RSVD, 8'hFF);
        send_request(OP_DATA, CH_AT);
        send_request(OP_DATA, 8'h61);
        send_request(OP_DATA, CH_SPACE);
        send_request(OP_DATA, 8'h63);
        send_request(OP_DATA, CH_CR);
        send_request(OP_DATA, CH_LF);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_DATA, 8'h00);
        send_request(OP_DATA, 8'h41);
        send_request(OP_DATA, CH_LF);
        send_request(OP_DATA, CH_PLUS);
        send_request(OP_DATA, CH_LF);
        send_request(OP_DATA, 8'h49);
        send_request(OP_DATA, CH_CR);
        send_request(OP_DATA, 8'h4A);
        send_request(OP_DATA, CH_LF);

        // Random well-formed records, some in burst stretches
        while (requests_sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 99) < 15);
            send_record();
            no_idle = 1'b0;
            if (!paused && requests_sent > PAUSE_AT) begin
                drain();
                paused = 1'b1;
            end
        end

        ending = t_ending'($urandom_range(0, 9));
        send_ending(ending);

        // Frozen block: every request gives one plain result
        repeat (30) send_request(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results, %0d records parsed",
                 requests_sent, checked, records);
        $display("Stream ended by %s, final status %s", ending.name(), final_status.name());
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/fqp_pkg.sv
src/fqp_parse.sv
src/fqp_result_fifo.sv
src/fastq_record_parser.sv
test/fastq_result_checker.sv
test/testbench.sv
